>>> rtl/vm_placement_objective_evaluator_unit_assert.svh
// Assertion macros shared by the placement evaluator RTL.
`ifndef VM_PLACEMENT_OBJECTIVE_EVALUATOR_UNIT_ASSERT_SVH
`define VM_PLACEMENT_OBJECTIVE_EVALUATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define VPOE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define VPOE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VPOE_ASSERT_IMP(lbl, ante, cons, msg)
`define VPOE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/vpoe_pkg.sv
// Types and constants shared by the placement evaluator modules.
`timescale 1ns / 1ps
package vpoe_pkg;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_EVAL   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_MACHINE_COUNT     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CRITICAL_CODE     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_COMMIT_CRITICAL   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_COMMIT_NONCRIT    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MOVE_COST_CRIT    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MOVE_COST_NONCRIT = 3'd5;
    localparam int CFG_DW = 16;

    // Result widths and saturation limits
    localparam int SUM_W   = 26;
    localparam int POWER_W = 40;
    localparam int DISP_W  = 24;
    localparam int MIG_W   = 26;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [POWER_W-1:0] POWER_MAX = '1;
    localparam logic [DISP_W-1:0]  DISP_MAX  = '1;
    localparam logic [MIG_W-1:0]   MIG_MAX   = '1;

    // Shared divider operand widths
    localparam int DIV_NW = 60;
    localparam int DIV_DW = 36;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  machine_index;
        logic [15:0] machine_cpu_capacity;
        logic [15:0] machine_peak_power;
        logic [15:0] machine_commitment;
        logic [5:0]  vm_host;
        logic [5:0]  vm_base_host;
        logic [15:0] vm_cpu;
        logic [15:0] vm_memory;
        logic [15:0] vm_storage;
        logic [7:0]  vm_class;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [5:0]         row_machine;
        logic [SUM_W-1:0]   cpu_used;
        logic [SUM_W-1:0]   memory_used;
        logic [SUM_W-1:0]   storage_used;
        logic [POWER_W-1:0] power_total;
        logic [DISP_W-1:0]  dispersion;
        logic [MIG_W-1:0]   migration_total;
        logic               divide_fault;
        logic               last;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic load_wr;
        logic add_rd;
        logic add_wr;
        logic ev_init;
        logic ev_row;
        logic ev_mul2;
        logic ev_mul3;
        logic div_start;
        logic pwr_acc;
        logic ev_next;
        logic disp1;
        logic disp2;
        logic disp_done;
        logic tot_load;
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic last_machine;
        logic cpu_nz;
        logic den_zero;
        logic div_done;
        logic disp_skip;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/vpoe_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps
interface vpoe_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/vpoe_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vpoe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vpoe_pkg::DIV_NW-1:0] i_num,
    input  logic [vpoe_pkg::DIV_DW-1:0] i_den,
    output logic                        o_done,
    output logic [vpoe_pkg::DIV_NW-1:0] o_quot
);
    localparam int NW = vpoe_pkg::DIV_NW;
    localparam int DW = vpoe_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [NW-1:0]    r_q;
    logic [DW:0]      trial;
    logic             q_bit;
    logic [DW-1:0]    n_rem;

    // Trial subtract of the shifted remainder
    always_comb begin
        trial = {r_rem, r_q[NW-1]};
        q_bit = (trial >= {1'b0, r_den});
        n_rem = q_bit ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
    end

    // Control: busy while the bit counter runs down, then a one-cycle done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[NW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> rtl/vpoe_datapath.sv
// Datapath: config registers, tables, sums, objective arithmetic, result register.
`timescale 1ns / 1ps
`include "vm_placement_objective_evaluator_unit_assert.svh"
module vpoe_datapath #(
    parameter int MAX_MACHINES = 64,
    parameter int MAX_VMS      = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vpoe_pkg::t_ctrl_cmd                i_cmd,
    output vpoe_pkg::t_dp_status               o_status,
    input  vpoe_pkg::t_in_item                 i_in_item,
    input  logic                               i_cfg_we,
    input  logic [vpoe_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [vpoe_pkg::CFG_DW-1:0]        i_cfg_wdata,
    output logic                               o_out_valid,
    output vpoe_pkg::t_out_item                o_out_item,
    input  logic                               i_out_ready
);
    localparam int AW    = $clog2(MAX_MACHINES);
    localparam int VCW   = $clog2(MAX_VMS + 1);
    localparam int SUM_W = vpoe_pkg::SUM_W;
    localparam int NW    = vpoe_pkg::DIV_NW;
    localparam int DW    = vpoe_pkg::DIV_DW;
    localparam int MW    = VCW + 17;

    typedef struct packed {
        logic             has_crit;
        logic             has_ncrit;
        logic [SUM_W-1:0] cpu;
        logic [SUM_W-1:0] mem;
        logic [SUM_W-1:0] sto;
    } t_sum_word;

    typedef struct packed {
        logic [15:0] cap;
        logic [15:0] peak;
        logic [15:0] commit;
    } t_tbl_word;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [15:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? vpoe_pkg::SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Configuration registers
    logic [5:0]  r_machine_count;
    logic [7:0]  r_critical_code;
    logic [15:0] r_commit_crit;
    logic [15:0] r_commit_ncrit;
    logic [15:0] r_cost_crit;
    logic [15:0] r_cost_ncrit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_count <= 6'd1;
            r_critical_code <= 8'd1;
            r_commit_crit   <= 16'd256;
            r_commit_ncrit  <= 16'd256;
            r_cost_crit     <= 16'd256;
            r_cost_ncrit    <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vpoe_pkg::CFG_MACHINE_COUNT:     r_machine_count <= i_cfg_wdata[5:0];
                vpoe_pkg::CFG_CRITICAL_CODE:     r_critical_code <= i_cfg_wdata[7:0];
                vpoe_pkg::CFG_COMMIT_CRITICAL:   r_commit_crit   <= i_cfg_wdata;
                vpoe_pkg::CFG_COMMIT_NONCRIT:    r_commit_ncrit  <= i_cfg_wdata;
                vpoe_pkg::CFG_MOVE_COST_CRIT:    r_cost_crit     <= i_cfg_wdata;
                vpoe_pkg::CFG_MOVE_COST_NONCRIT: r_cost_ncrit    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accepted transaction
    vpoe_pkg::t_in_item r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_in_item;
    end

    logic          idx_ok, host_ok, crit, vm_full;
    logic [AW-1:0] idx_addr, host_addr, rd_addr;
    assign idx_ok    = (r_item.machine_index != '0) &&
                       (32'(r_item.machine_index) < 32'(MAX_MACHINES));
    assign host_ok   = (r_item.vm_host != '0) &&
                       (32'(r_item.vm_host) < 32'(MAX_MACHINES));
    assign idx_addr  = AW'(r_item.machine_index);
    assign host_addr = AW'(r_item.vm_host);
    assign crit      = (r_item.vm_class == r_critical_code);

    // Machine walk index
    logic [AW-1:0] r_m;
    logic [AW-1:0] count_eff;
    assign count_eff = (32'(r_machine_count) >= 32'(MAX_MACHINES)) ?
                       AW'(MAX_MACHINES - 1) : AW'(r_machine_count);
    assign rd_addr   = i_cmd.add_rd ? host_addr : r_m;

    // Machine table memory
    t_tbl_word r_tbl_mem [MAX_MACHINES];
    t_tbl_word r_tbl_rd;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && idx_ok) begin
            r_tbl_mem[idx_addr] <= '{cap:    r_item.machine_cpu_capacity,
                                     peak:   r_item.machine_peak_power,
                                     commit: r_item.machine_commitment};
        end
        r_tbl_rd <= r_tbl_mem[r_m];
    end

    // Per-machine sum memory; an entry without its valid bit reads as zero
    t_sum_word               r_sum_mem [MAX_MACHINES];
    t_sum_word               r_sum_rd;
    logic                    r_sum_rd_vld;
    logic [MAX_MACHINES-1:0] r_sum_vld;
    t_sum_word               sum_eff;
    t_sum_word               sum_new;
    logic                    add_live;

    assign sum_eff  = r_sum_rd_vld ? r_sum_rd : '0;
    assign add_live = i_cmd.add_wr && !vm_full && host_ok;

    always_comb begin
        sum_new           = sum_eff;
        sum_new.cpu       = sat_add(sum_eff.cpu, r_item.vm_cpu);
        sum_new.mem       = sat_add(sum_eff.mem, r_item.vm_memory);
        sum_new.sto       = sat_add(sum_eff.sto, r_item.vm_storage);
        sum_new.has_crit  = sum_eff.has_crit | crit;
        sum_new.has_ncrit = sum_eff.has_ncrit | !crit;
    end

    always_ff @(posedge i_clk) begin
        if (add_live) r_sum_mem[host_addr] <= sum_new;
        r_sum_rd <= r_sum_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld    <= '0;
            r_sum_rd_vld <= 1'b0;
        end else begin
            r_sum_rd_vld <= r_sum_vld[rd_addr];
            if (i_cmd.tot_load) r_sum_vld <= '0;
            else if (add_live) r_sum_vld[host_addr] <= 1'b1;
        end
    end

    // Placement counters
    logic [VCW-1:0] r_vm_total, r_crit_total, r_moved_crit, r_moved_ncrit;
    logic [VCW-1:0] rest;
    assign vm_full = (r_vm_total >= VCW'(MAX_VMS));
    assign rest    = r_vm_total - r_crit_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.tot_load) begin
            r_vm_total    <= '0;
            r_crit_total  <= '0;
            r_moved_crit  <= '0;
            r_moved_ncrit <= '0;
        end else if (i_cmd.add_wr && !vm_full) begin
            r_vm_total <= r_vm_total + 1'b1;
            if (crit) r_crit_total <= r_crit_total + 1'b1;
            if (r_item.vm_host != r_item.vm_base_host) begin
                if (crit) r_moved_crit <= r_moved_crit + 1'b1;
                else r_moved_ncrit <= r_moved_ncrit + 1'b1;
            end
        end
    end

    // Shared divider
    logic [NW-1:0] r_div_num;
    logic [DW-1:0] r_div_den;
    logic          div_done;
    logic [NW-1:0] div_quot;

    vpoe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Evaluation walk: classification and power
    logic [5:0]                    r_cs, r_ncs;
    logic [31:0]                   r_den;
    logic [35:0]                   r_a;
    logic [35:0]                   r_d5;
    logic [vpoe_pkg::POWER_W-1:0]  r_power;
    logic                          r_fault;
    logic                          same_commit;
    logic [NW:0]                   pwr_sum;
    logic [51:0]                   pa;

    assign same_commit = (r_commit_crit == r_commit_ncrit);
    assign pwr_sum     = (NW + 1)'(r_power) + (NW + 1)'(div_quot);
    assign pa          = r_tbl_rd.peak * r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m   <= '0;
            r_cs  <= '0;
            r_ncs <= '0;
        end else if (i_cmd.ev_init) begin
            r_m   <= AW'(1);
            r_cs  <= '0;
            r_ncs <= '0;
        end else begin
            if (i_cmd.ev_next) r_m <= r_m + 1'b1;
            if (i_cmd.ev_row && (sum_eff.cpu != '0)) begin
                if (same_commit) begin
                    r_cs  <= r_cs + 6'(sum_eff.has_crit);
                    r_ncs <= r_ncs + 6'(sum_eff.has_ncrit);
                end else if (r_tbl_rd.commit == r_commit_crit) begin
                    r_cs  <= r_cs + 1'b1;
                    r_ncs <= r_ncs + 6'(sum_eff.has_ncrit);
                end else begin
                    r_ncs <= r_ncs + 1'b1;
                end
            end
        end
    end

    // Dispersion and migration operands
    logic [11:0]     r_t1;
    logic [VCW+5:0]  r_t2, r_t3;
    logic [VCW+15:0] r_mc, r_mn;
    logic [17:0]     t1ncs;
    logic [VCW+6:0]  dden;
    logic [MW-1:0]   mig_sum;
    logic            disp_skip;
    logic [NW-1:0]   dnum_sel;
    logic [DW-1:0]   dden_sel;

    assign t1ncs   = r_t1 * r_ncs;
    assign dden    = (VCW + 7)'(r_t2) + (VCW + 7)'(r_t3);
    assign mig_sum = MW'(r_mc) + MW'(r_mn);

    always_comb begin
        if ((r_cs != '0) && (r_ncs != '0)) begin
            disp_skip = (dden == '0);
            dnum_sel  = NW'({t1ncs, 8'd0});
            dden_sel  = DW'(dden);
        end else if (r_cs == '0) begin
            disp_skip = (r_ncs == '0);
            dnum_sel  = NW'({rest, 8'd0});
            dden_sel  = DW'(r_ncs);
        end else begin
            disp_skip = 1'b0;
            dnum_sel  = NW'({r_crit_total, 8'd0});
            dden_sel  = DW'(r_cs);
        end
    end

    logic [vpoe_pkg::DISP_W-1:0] r_disp;
    logic [vpoe_pkg::MIG_W-1:0]  r_mig;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_init) begin
            r_power <= '0;
            r_fault <= 1'b0;
        end
        if (i_cmd.ev_row) r_den <= r_tbl_rd.cap * r_tbl_rd.commit;
        if (i_cmd.ev_mul2) begin
            if (r_den == '0) r_fault <= 1'b1;
            r_a  <= 36'(r_den) + 36'({r_den, 1'b0}) + 36'({sum_eff.cpu, 9'd0});
            r_d5 <= 36'(r_den) + 36'({r_den, 2'b00});
        end
        if (i_cmd.ev_mul3) begin
            r_div_num <= {pa, 8'd0};
            r_div_den <= r_d5;
        end
        if (i_cmd.pwr_acc) begin
            r_power <= (pwr_sum > (NW + 1)'(vpoe_pkg::POWER_MAX)) ?
                       vpoe_pkg::POWER_MAX : vpoe_pkg::POWER_W'(pwr_sum);
        end
        if (i_cmd.disp1) begin
            r_t1 <= r_cs * r_cs;
            r_t2 <= r_crit_total * r_ncs;
            r_t3 <= rest * r_cs;
            r_mc <= r_moved_crit * r_cost_crit;
            r_mn <= r_moved_ncrit * r_cost_ncrit;
        end
        if (i_cmd.disp2) begin
            r_disp    <= '0;
            r_div_num <= dnum_sel;
            r_div_den <= dden_sel;
            if (disp_skip) r_fault <= 1'b1;
            r_mig <= (mig_sum > MW'(vpoe_pkg::MIG_MAX)) ?
                     vpoe_pkg::MIG_MAX : vpoe_pkg::MIG_W'(mig_sum);
        end
        if (i_cmd.disp_done) begin
            r_disp <= (div_quot > NW'(vpoe_pkg::DISP_MAX)) ?
                      vpoe_pkg::DISP_MAX : vpoe_pkg::DISP_W'(div_quot);
        end
    end

    // Result register
    logic                r_out_valid;
    vpoe_pkg::t_out_item r_out;
    logic                out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ev_row || i_cmd.tot_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_row) begin
            r_out              <= '0;
            r_out.row_machine  <= 6'(r_m);
            r_out.cpu_used     <= sum_eff.cpu;
            r_out.memory_used  <= sum_eff.mem;
            r_out.storage_used <= sum_eff.sto;
        end else if (i_cmd.tot_load) begin
            r_out                 <= '0;
            r_out.kind            <= 1'b1;
            r_out.power_total     <= r_power;
            r_out.dispersion      <= r_disp;
            r_out.migration_total <= r_mig;
            r_out.divide_fault    <= r_fault;
            r_out.last            <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status = '{count_zero:   (count_eff == '0),
                        last_machine: (r_m == count_eff),
                        cpu_nz:       (sum_eff.cpu != '0),
                        den_zero:     (r_den == '0),
                        div_done:     div_done,
                        disp_skip:    disp_skip,
                        out_free:     out_free};

    `VPOE_ASSERT_NXT(a_sums_cleared, i_cmd.tot_load, r_sum_vld == '0, "sums not cleared after totals")
    `VPOE_ASSERT_IMP(a_cs_bound, 1'b1, 32'(r_cs) <= 32'(r_m), "critical machine count exceeds walk")
    `VPOE_ASSERT_IMP(a_row_room, i_cmd.ev_row || i_cmd.tot_load, out_free, "result register overwritten")
endmodule

>>> rtl/vpoe_ctrl.sv
// Controller state machine sequencing loads, adds and the evaluation walk.
`timescale 1ns / 1ps
`include "vm_placement_objective_evaluator_unit_assert.svh"
module vpoe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_in_action,
    output logic                  o_in_ready,
    input  vpoe_pkg::t_dp_status  i_status,
    output vpoe_pkg::t_ctrl_cmd   o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_ADD_RD, S_ADD_WR, S_EV_INIT, S_EV_RD, S_EV_ROW,
        S_EV_MUL2, S_EV_MUL3, S_EV_DIV, S_EV_WAIT, S_EV_NEXT, S_DISP1,
        S_DISP2, S_DDIV, S_DWAIT, S_TOT
    } t_state;

    t_state r_state, n_state;
    vpoe_pkg::t_ctrl_cmd cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    case (i_in_action)
                        vpoe_pkg::ACT_LOAD: n_state = S_LOAD;
                        vpoe_pkg::ACT_ADD:  n_state = S_ADD_RD;
                        vpoe_pkg::ACT_EVAL: n_state = S_EV_INIT;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                cmd.load_wr = 1'b1;
                n_state     = S_IDLE;
            end
            S_ADD_RD: begin
                cmd.add_rd = 1'b1;
                n_state    = S_ADD_WR;
            end
            S_ADD_WR: begin
                cmd.add_wr = 1'b1;
                n_state    = S_IDLE;
            end
            S_EV_INIT: begin
                cmd.ev_init = 1'b1;
                n_state     = i_status.count_zero ? S_DISP1 : S_EV_RD;
            end
            S_EV_RD: n_state = S_EV_ROW;
            S_EV_ROW: begin
                if (i_status.out_free) begin
                    cmd.ev_row = 1'b1;
                    n_state    = i_status.cpu_nz ? S_EV_MUL2 : S_EV_NEXT;
                end
            end
            S_EV_MUL2: begin
                cmd.ev_mul2 = 1'b1;
                n_state     = i_status.den_zero ? S_EV_NEXT : S_EV_MUL3;
            end
            S_EV_MUL3: begin
                cmd.ev_mul3 = 1'b1;
                n_state     = S_EV_DIV;
            end
            S_EV_DIV: begin
                cmd.div_start = 1'b1;
                n_state       = S_EV_WAIT;
            end
            S_EV_WAIT: begin
                if (i_status.div_done) begin
                    cmd.pwr_acc = 1'b1;
                    n_state     = S_EV_NEXT;
                end
            end
            S_EV_NEXT: begin
                if (i_status.last_machine) begin
                    n_state = S_DISP1;
                end else begin
                    cmd.ev_next = 1'b1;
                    n_state     = S_EV_RD;
                end
            end
            S_DISP1: begin
                cmd.disp1 = 1'b1;
                n_state   = S_DISP2;
            end
            S_DISP2: begin
                cmd.disp2 = 1'b1;
                n_state   = i_status.disp_skip ? S_TOT : S_DDIV;
            end
            S_DDIV: begin
                cmd.div_start = 1'b1;
                n_state       = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) begin
                    cmd.disp_done = 1'b1;
                    n_state       = S_TOT;
                end
            end
            S_TOT: begin
                if (i_status.out_free) begin
                    cmd.tot_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    `VPOE_ASSERT_IMP(a_div_done_wait, i_status.div_done, (r_state == S_EV_WAIT) || (r_state == S_DWAIT), "divider finished outside a wait state")
    `VPOE_ASSERT_NXT(a_add_pair, r_state == S_ADD_RD, r_state == S_ADD_WR, "add read not followed by write")
endmodule

>>> rtl/vm_placement_objective_evaluator_unit.sv
// Top level of the placement objective evaluator.
// Per transaction: load accepts the item, then writes the machine table; add reads, then
// writes (read-modify-write of the sum memory). Evaluate starts the walk, then reads each
// machine's row; a busy machine with a nonzero divisor then waits on the shared divider.
// The totals row waits on a dispersion division unless the dispersion divisor is zero.
// Each row also waits while the one-entry output register is full.
// Synchronous active-low reset restores config defaults, control, sum valid bits, counters.
`timescale 1ns / 1ps
module vm_placement_objective_evaluator_unit #(
    parameter int MAX_MACHINES = 64,
    parameter int MAX_VMS      = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vpoe_stream_if.sink                   i_in_ch,
    vpoe_stream_if.source                 o_out_ch,
    input  logic                          i_cfg_we,
    input  logic [vpoe_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [vpoe_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    vpoe_pkg::t_ctrl_cmd  cmd;
    vpoe_pkg::t_dp_status status;
    vpoe_pkg::t_in_item   in_item;
    vpoe_pkg::t_out_item  out_item;
    logic                 in_ready;
    logic                 out_valid;

    assign in_item = i_in_ch.payload;

    vpoe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_in_action (in_item.action),
        .o_in_ready  (in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vpoe_datapath #(
        .MAX_MACHINES (MAX_MACHINES),
        .MAX_VMS      (MAX_VMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_ready (o_out_ch.ready)
    );

    assign i_in_ch.ready    = in_ready;
    assign o_out_ch.valid   = out_valid;
    assign o_out_ch.payload = out_item;
endmodule
